// File: hdl/usb_pd_message_decoder_defines.svh
// Assertion macros shared by the message decoder modules.
`ifndef USB_PD_MESSAGE_DECODER_DEFINES_SVH
`define USB_PD_MESSAGE_DECODER_DEFINES_SVH

// Each macro expects clk and arst_n in the scope where it is used.
`define UPD_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

`define UPD_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define UPD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/upd_pkg.sv
// Types and constants of the USB PD message decoder.
`timescale 1ns / 1ps
package upd_pkg;

	localparam int unsigned NUM_CAPS = 7;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_OBJECT = 2'd1,
		KIND_SHORT  = 2'd2,
		KIND_END    = 2'd3
	} kind_t;

	localparam logic [3:0] CLS_FIXED     = 4'd0;
	localparam logic [3:0] CLS_BATTERY   = 4'd1;
	localparam logic [3:0] CLS_VARIABLE  = 4'd2;
	localparam logic [3:0] CLS_PPS       = 4'd3;
	localparam logic [3:0] CLS_APDO      = 4'd4;
	localparam logic [3:0] CLS_RDO_PPS   = 4'd5;
	localparam logic [3:0] CLS_RDO_VOLT  = 4'd6;
	localparam logic [3:0] CLS_RDO_CURR  = 4'd7;
	localparam logic [3:0] CLS_RAW       = 4'd8;

	localparam logic [4:0] MSG_SOURCE_CAP = 5'd1;
	localparam logic [4:0] MSG_REQUEST    = 5'd2;
	localparam logic [4:0] MSG_SINK_CAP   = 5'd4;

	localparam logic [1:0] SUPPLY_FIXED    = 2'd0;
	localparam logic [1:0] SUPPLY_BATTERY  = 2'd1;
	localparam logic [1:0] SUPPLY_VARIABLE = 2'd2;
	localparam logic [1:0] SUPPLY_APDO     = 2'd3;

	// One queue entry: up to one header or object result, then an optional end mark.
	typedef struct packed {
		logic        main_vld;
		logic        main_obj;
		logic [15:0] hdr;
		logic [31:0] word;
		logic [2:0]  idx;
		logic        end_vld;
		logic        end_short;
	} upd_entry_t;

	typedef struct packed {
		kind_t       kind;
		logic [4:0]  msg_type;
		logic        is_extended;
		logic        power_role;
		logic [2:0]  obj_count;
		logic [2:0]  obj_index;
		logic [3:0]  object_class;
		logic [15:0] volt_max_mv;
		logic [15:0] volt_min_mv;
		logic [17:0] amount;
		logic [31:0] raw_word;
	} upd_result_t;

endpackage

// File: hdl/upd_front.sv
// Byte framing: header capture, word assembly and queue entry generation.
`timescale 1ns / 1ps
`include "usb_pd_message_decoder_defines.svh"
module upd_front import upd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] byte_value,
	input  logic       end_of_packet,
	output upd_entry_t entry,
	output logic       entry_vld
);

	logic [4:0]  pos_q;
	logic [15:0] hdr_q;
	logic [23:0] word_q;
	logic [15:0] hdr_d;
	logic [23:0] word_d;
	logic [4:0]  rel;
	logic [2:0]  idx;

	assign rel = pos_q - 5'd2;
	assign idx = rel[4:2];

	always_comb begin
		entry = '0;
		hdr_d = hdr_q;
		word_d = word_q;
		if (pos_q == 5'd0) begin
			hdr_d = {8'h00, byte_value};
		end else if (pos_q == 5'd1) begin
			hdr_d = {byte_value, hdr_q[7:0]};
			entry.main_vld = 1'b1;
			entry.main_obj = 1'b0;
			entry.hdr = hdr_d;
		end else begin
			unique case (rel[1:0])
				2'd0: word_d = {16'h0000, byte_value};
				2'd1: word_d = word_q | {8'h00, byte_value, 8'h00};
				2'd2: word_d = word_q | {byte_value, 16'h0000};
				2'd3: begin
					word_d = '0;
					// Objects beyond the header count or NUM_CAPS, or in extended messages, are dropped.
					if (!hdr_q[15] && (idx < hdr_q[14:12]) && (idx < 3'(NUM_CAPS))) begin
						entry.main_vld = 1'b1;
						entry.main_obj = 1'b1;
						entry.hdr = hdr_q;
						entry.word = {byte_value, word_q};
						entry.idx = idx;
					end
				end
			endcase
		end
		entry.end_vld = end_of_packet;
		entry.end_short = (pos_q == 5'd0);
	end

	assign entry_vld = entry.main_vld || entry.end_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			hdr_q <= '0;
			word_q <= '0;
		end else if (accept) begin
			if (end_of_packet) begin
				pos_q <= '0;
				hdr_q <= '0;
				word_q <= '0;
			end else begin
				if (pos_q != 5'd31) begin
					pos_q <= pos_q + 5'd1;
				end
				hdr_q <= hdr_d;
				word_q <= word_d;
			end
		end
	end

	`UPD_ASSERT_NEXT(a_eop_clears, accept && end_of_packet, pos_q == 5'd0 && word_q == 24'd0, "packet end did not clear framing state")

endmodule

// File: hdl/upd_queue.sv
// Short first-in first-out queue between the framing and decoding parts.
`timescale 1ns / 1ps
`include "usb_pd_message_decoder_defines.svh"
module upd_queue import upd_pkg::*; #(
	parameter int unsigned DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  upd_entry_t push_data,
	input  logic       pop,
	output upd_entry_t head,
	output logic       full,
	output logic       empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	upd_entry_t         mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	`UPD_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(DEPTH), "queue count exceeds depth")
	`UPD_ASSERT_NEXT(a_count_grows, push && !pop, count_q == $past(count_q) + CNT_W'(1), "queue count did not follow a lone write")

endmodule

// File: hdl/upd_back.sv
// Object decoding, source capability cache and the result register.
`timescale 1ns / 1ps
`include "usb_pd_message_decoder_defines.svh"
module upd_back import upd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  upd_entry_t  head,
	input  logic        head_vld,
	output logic        q_pop,
	input  logic        pop,
	output logic        empty,
	output upd_result_t result
);

	logic [31:0] cache_q [NUM_CAPS];
	logic [2:0]  cap_q;
	logic        phase_q;
	logic        out_vld_q;
	upd_result_t res_q;
	upd_result_t res_d;

	logic        emit_main;
	logic        last;
	logic        advance;
	logic        is_src_cap;
	logic        clear_caps;
	logic [31:0] w;
	logic [2:0]  rdo_pos;
	logic        found;
	logic [31:0] src;
	logic        src_pps;

	assign emit_main = head.main_vld && !phase_q;
	assign last = !(emit_main && head.end_vld);
	assign advance = head_vld && (!out_vld_q || pop);
	assign q_pop = advance && last;
	assign w = head.word;
	assign is_src_cap = (head.hdr[4:0] == MSG_SOURCE_CAP);
	assign clear_caps = !head.hdr[15] && (head.hdr[14:12] != 3'd0) && is_src_cap;

	assign rdo_pos = w[30:28];
	assign found = (rdo_pos != 3'd0) && (rdo_pos <= cap_q);
	assign src = found ? cache_q[rdo_pos - 3'd1] : '0;
	assign src_pps = (src[31:30] == SUPPLY_APDO) && (src[29:28] == 2'd0);

	always_comb begin
		res_d = '0;
		if (emit_main) begin
			res_d.msg_type = head.hdr[4:0];
			res_d.is_extended = head.hdr[15];
			res_d.power_role = head.hdr[8];
			res_d.obj_count = head.hdr[14:12];
			if (!head.main_obj) begin
				res_d.kind = KIND_HEADER;
				res_d.raw_word = {16'h0000, head.hdr};
			end else begin
				res_d.kind = KIND_OBJECT;
				res_d.obj_index = head.idx + 3'd1;
				res_d.raw_word = w;
				res_d.object_class = CLS_RAW;
				if (is_src_cap || head.hdr[4:0] == MSG_SINK_CAP) begin
					unique case (w[31:30])
						SUPPLY_FIXED: begin
							res_d.object_class = CLS_FIXED;
							res_d.volt_max_mv = 16'(w[19:10]) * 16'd50;
							res_d.amount = 18'(w[9:0]) * 18'd10;
						end
						SUPPLY_BATTERY: begin
							res_d.object_class = CLS_BATTERY;
							res_d.volt_max_mv = 16'(w[29:20]) * 16'd50;
							res_d.volt_min_mv = 16'(w[19:10]) * 16'd50;
							res_d.amount = 18'(w[9:0]) * 18'd250;
						end
						SUPPLY_VARIABLE: begin
							res_d.object_class = CLS_VARIABLE;
							res_d.volt_max_mv = 16'(w[29:20]) * 16'd50;
							res_d.volt_min_mv = 16'(w[19:10]) * 16'd50;
							res_d.amount = 18'(w[9:0]) * 18'd10;
						end
						SUPPLY_APDO: begin
							if (w[29:28] == 2'd0) begin
								res_d.object_class = CLS_PPS;
								res_d.volt_max_mv = 16'(w[24:17]) * 16'd100;
								res_d.volt_min_mv = 16'(w[15:8]) * 16'd100;
								res_d.amount = 18'(w[6:0]) * 18'd50;
							end else begin
								res_d.object_class = CLS_APDO;
							end
						end
					endcase
				end else if (head.hdr[4:0] == MSG_REQUEST) begin
					// The source object that the request points to selects the layout.
					if (found && src_pps) begin
						res_d.object_class = CLS_RDO_PPS;
						res_d.volt_max_mv = 16'(w[19:9]) * 16'd20;
						res_d.amount = 18'(w[6:0]) * 18'd50;
					end else begin
						res_d.object_class = CLS_RDO_CURR;
						res_d.amount = 18'(w[19:10]) * 18'd10;
						if (found && (src[31:30] == SUPPLY_FIXED || src[31:30] == SUPPLY_VARIABLE)
								&& (src[19:10] != 10'd0)) begin
							res_d.object_class = CLS_RDO_VOLT;
							res_d.volt_max_mv = 16'(src[19:10]) * 16'd50;
						end
					end
				end
			end
		end else begin
			res_d.kind = head.end_short ? KIND_SHORT : KIND_END;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit_main && head.main_obj && is_src_cap) begin
			cache_q[head.idx] <= w;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= '0;
			phase_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (advance) begin
				out_vld_q <= 1'b1;
				phase_q <= !last;
				if (emit_main && !head.main_obj && clear_caps) begin
					cap_q <= '0;
				end else if (emit_main && head.main_obj && is_src_cap) begin
					cap_q <= head.idx + 3'd1;
				end
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign empty = !out_vld_q;
	assign result = res_q;

	`UPD_ASSERT_IMPLIES(a_phase_has_end, phase_q, head_vld && head.main_vld && head.end_vld, "second transfer pending without a two-result entry")
	`UPD_ASSERT_NEXT(a_cap_tracks, advance && emit_main && head.main_obj && is_src_cap, cap_q == $past(head.idx) + 3'd1, "capability count not updated")

endmodule

// File: hdl/usb_pd_message_decoder.sv
// USB PD message decoder: one byte per cycle in unless full, decoded results out.
// Each result passes through the queue and the result register to the output ports.
// Throughput: one byte per cycle while the queue is not full; a byte that ends a packet
// and also completes a header or object gives two results, sent one after the other.
// The queue between framing and decode absorbs the extra result and output stalls.
// Reset clears framing, queue and capability count; cached objects hold no reset value.
`timescale 1ns / 1ps
module usb_pd_message_decoder import upd_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  byte_value,
	input  logic        end_of_packet,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  result_kind,
	output logic [4:0]  msg_type,
	output logic        is_extended,
	output logic        power_role,
	output logic [2:0]  obj_count,
	output logic [2:0]  obj_index,
	output logic [3:0]  object_class,
	output logic [15:0] volt_max_mv,
	output logic [15:0] volt_min_mv,
	output logic [17:0] amount,
	output logic [31:0] raw_word
);

	logic        accept;
	upd_entry_t  entry;
	logic        entry_vld;
	upd_entry_t  head;
	logic        q_empty;
	logic        q_pop;
	upd_result_t result;

	assign accept = push && !full;

	upd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.byte_value    (byte_value),
		.end_of_packet (end_of_packet),
		.entry         (entry),
		.entry_vld     (entry_vld)
	);

	upd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && entry_vld),
		.push_data (entry),
		.pop       (q_pop),
		.head      (head),
		.full      (full),
		.empty     (q_empty)
	);

	upd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.head_vld (!q_empty),
		.q_pop    (q_pop),
		.pop      (pop),
		.empty    (empty),
		.result   (result)
	);

	assign result_kind  = result.kind;
	assign msg_type     = result.msg_type;
	assign is_extended  = result.is_extended;
	assign power_role   = result.power_role;
	assign obj_count    = result.obj_count;
	assign obj_index    = result.obj_index;
	assign object_class = result.object_class;
	assign volt_max_mv  = result.volt_max_mv;
	assign volt_min_mv  = result.volt_min_mv;
	assign amount       = result.amount;
	assign raw_word     = result.raw_word;

endmodule
